### rtl/mbrot_pkg.sv
// Shared constants and types of the escape-time pixel unit.
package mbrot_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_REG_W  = 13;
    localparam int LIMIT_W    = 16;
    localparam int COORD_W    = 12;
    localparam int INT_W      = 8;
    localparam int CHUNK_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

    localparam logic [DIM_REG_W-1:0] RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [DIM_REG_W-1:0] RST_IMAGE_HEIGHT    = 13'd480;
    localparam logic [LIMIT_W-1:0]   RST_ITERATION_LIMIT = 16'd256;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

### rtl/mbrot_mul.sv
// Shared signed fixed-point multiplier, one 32-bit chunk of the second operand per cycle.
module mbrot_mul
    import mbrot_pkg::*;
#(
    parameter int A_W   = 31,
    parameter int FRAC  = 26,
    parameter int RES_W = 34
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [A_W-1:0]   i_b,
    output t_unit_sts               o_sts,
    output logic signed [RES_W-1:0] o_prod
);

    localparam int NCH   = (A_W + CHUNK_W - 1) / CHUNK_W;
    localparam int B_W   = NCH * CHUNK_W;
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(NCH + 1);

    logic signed [A_W-1:0]     r_a;
    logic        [B_W-1:0]     r_b;
    logic signed [P_W-1:0]     r_acc;
    logic        [CNT_W-1:0]   r_cnt;
    logic                      r_done;

    logic        [CHUNK_W-1:0] chunk;
    logic signed [CHUNK_W:0]   chunk_ext;
    logic signed [A_W+CHUNK_W:0] pp;
    logic signed [P_W-1:0]     n_acc;

    always_comb begin
        chunk = r_b[B_W-1 -: CHUNK_W];
        // the top chunk carries the sign, the rest are magnitudes
        if (r_cnt == CNT_W'(NCH)) begin
            chunk_ext = $signed({chunk[CHUNK_W-1], chunk});
        end else begin
            chunk_ext = $signed({1'b0, chunk});
        end
        pp    = r_a * chunk_ext;
        n_acc = (r_acc <<< CHUNK_W) + P_W'(pp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= i_a;
                r_b   <= B_W'(i_b);
                r_acc <= '0;
                r_cnt <= CNT_W'(NCH);
            end else if (r_cnt != '0) begin
                r_acc  <= n_acc;
                r_b    <= r_b << CHUNK_W;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign o_prod     = RES_W'(r_acc >>> FRAC);
    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;

endmodule

### rtl/mbrot_div.sv
// Shared restoring divider, one quotient bit per cycle.
module mbrot_div
    import mbrot_pkg::*;
#(
    parameter int Q_W = 28,
    parameter int D_W = 16,
    parameter int S_W = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [D_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_low,
    input  logic [S_W-1:0] i_steps,
    input  logic [D_W-1:0] i_div,
    output t_unit_sts      o_sts,
    output logic [Q_W-1:0] o_quot
);

    logic [D_W-1:0] r_rem;
    logic [Q_W-1:0] r_low;
    logic [Q_W-1:0] r_q;
    logic [D_W-1:0] r_d;
    logic [S_W-1:0] r_cnt;
    logic           r_done;

    logic [D_W:0]   trial;
    logic           ge;
    logic [D_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_low[Q_W-1]};
        ge    = (trial >= {1'b0, r_d});
        // remainder stays below the divisor, so it fits D_W bits
        if (ge) begin
            n_rem = D_W'(trial - {1'b0, r_d});
        end else begin
            n_rem = D_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= i_rem;
                r_low <= i_low;
                r_q   <= '0;
                r_d   <= i_div;
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_rem  <= n_rem;
                r_low  <= r_low << 1;
                r_q    <= {r_q[Q_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == S_W'(1));
            end
        end
    end

    assign o_quot     = r_q;
    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;

endmodule

### rtl/mandelbrot_escape_time_pixel_unit.sv
// Mandelbrot escape-time pixel unit: pixel to point mapping, iteration and grey level.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_pixel_column, i_pixel_row
//  out     | source    | o_out_valid / i_out_stall  | o_iteration_count, o_intensity,
//          |           |                            | o_out_of_frame
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An out-of-frame pixel goes straight to the output. A pixel in the frame takes two
// divisions in the shared divider for the point, then up to three products per
// iteration in the shared multiplier, one pass per 32-bit chunk of its FRAC_BITS+5-bit
// operand, and one more division for the grey level unless the limit is zero.
// One pixel is in flight at a time; the input stalls until its beat has moved to the
// output register, which holds it while the next pixel is taken. Reset is synchronous.
module mandelbrot_escape_time_pixel_unit
    import mbrot_pkg::*;
#(
    parameter int FRAC_BITS     = 26,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_W-1:0]    i_pixel_column,
    input  logic [COORD_W-1:0]    i_pixel_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [LIMIT_W-1:0]    o_iteration_count,
    output logic [INT_W-1:0]      o_intensity,
    output logic                  o_out_of_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ZW    = FRAC_BITS + 4;
    localparam int MW    = FRAC_BITS + 5;
    localparam int RW    = FRAC_BITS + 8;
    localparam int QW    = FRAC_BITS + 2;
    localparam int SW    = $clog2(QW + 1);
    localparam int DIMW  = ($clog2(MAX_DIMENSION + 1) > DIM_REG_W) ?
                           $clog2(MAX_DIMENSION + 1) : DIM_REG_W;
    localparam int DVW   = (DIMW > LIMIT_W) ? DIMW : LIMIT_W;
    localparam int SCL_W = LIMIT_W + INT_W;

    localparam logic [ZW-1:0] TWO_FX       = ZW'(1) << (FRAC_BITS + 1);
    localparam logic [ZW-1:0] THREE_HALF_FX = ZW'(3) << (FRAC_BITS - 1);
    localparam logic [RW:0]   FOUR_FX      = (RW + 1)'(1) << (FRAC_BITS + 2);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_CR, S_DIV_CI, S_LOOP, S_MUL_RR, S_MUL_II, S_MUL_RI,
        S_SCALE, S_DIV_N, S_DONE
    } t_state;

    t_state                r_state;
    logic [DIM_REG_W-1:0]  r_width;
    logic [DIM_REG_W-1:0]  r_height;
    logic [LIMIT_W-1:0]    r_limit;

    logic [COORD_W-1:0]    r_row;
    logic signed [ZW-1:0]  r_cr;
    logic signed [ZW-1:0]  r_ci;
    logic signed [ZW-1:0]  r_zr;
    logic signed [ZW-1:0]  r_zi;
    logic signed [RW-1:0]  r_rr;
    logic signed [RW-1:0]  r_ii;
    logic [LIMIT_W-1:0]    r_count;
    logic [INT_W-1:0]      r_intensity;
    logic                  r_oof;

    logic                  r_out_valid;
    logic [LIMIT_W-1:0]    r_out_count;
    logic [INT_W-1:0]      r_out_int;
    logic                  r_out_oof;

    logic                  r_mul_start;
    logic signed [MW-1:0]  r_mul_a;
    logic signed [MW-1:0]  r_mul_b;
    logic                  r_div_start;
    logic [DVW-1:0]        r_div_rem;
    logic [QW-1:0]         r_div_low;
    logic [SW-1:0]         r_div_steps;
    logic [DVW-1:0]        r_div_d;

    t_unit_sts             mul_sts;
    t_unit_sts             div_sts;
    logic signed [RW-1:0]  mul_prod;
    logic [QW-1:0]         div_quot;

    logic [DIMW-1:0]       dim_w;
    logic [DIMW-1:0]       dim_h;
    logic [COORD_W+1:0]    row3;
    logic [SCL_W-1:0]      scaled;
    logic signed [RW:0]    n_mag;
    logic signed [RW-1:0]  n_zr;
    logic signed [RW-1:0]  n_zi;

    always_comb begin
        dim_w  = (r_width > MAX_DIMENSION) ? DIMW'(MAX_DIMENSION) : DIMW'(r_width);
        dim_h  = (r_height > MAX_DIMENSION) ? DIMW'(MAX_DIMENSION) : DIMW'(r_height);
        row3   = {1'b0, r_row, 1'b0} + {2'b00, r_row};
        // count * 255 without a multiplier
        scaled = {r_count, {INT_W{1'b0}}} - SCL_W'(r_count);
        n_mag  = (RW + 1)'(r_rr) + (RW + 1)'(mul_prod);
        n_zr   = r_rr - r_ii + RW'(r_cr);
        n_zi   = mul_prod + RW'(r_ci);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_width     <= RST_IMAGE_WIDTH;
            r_height    <= RST_IMAGE_HEIGHT;
            r_limit     <= RST_ITERATION_LIMIT;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;

            // a finished pixel reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:     r_width  <= i_cfg_data[DIM_REG_W-1:0];
                    CFG_IMAGE_HEIGHT:    r_height <= i_cfg_data[DIM_REG_W-1:0];
                    CFG_ITERATION_LIMIT: r_limit  <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_row <= i_pixel_row;
                        if ((DIMW'(i_pixel_column) >= dim_w) ||
                            (DIMW'(i_pixel_row) >= dim_h)) begin
                            r_oof       <= 1'b1;
                            r_count     <= '0;
                            r_intensity <= '0;
                            r_state     <= S_DONE;
                        end else begin
                            r_oof       <= 1'b0;
                            r_div_rem   <= DVW'(i_pixel_column);
                            r_div_low   <= '0;
                            r_div_steps <= SW'(QW);
                            r_div_d     <= DVW'(dim_w);
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV_CR;
                        end
                    end
                end
                S_DIV_CR: begin
                    if (div_sts.done) begin
                        r_cr        <= $signed(ZW'(div_quot) - TWO_FX);
                        r_div_rem   <= DVW'(row3[COORD_W+1:2]);
                        r_div_low   <= {row3[1:0], {FRAC_BITS{1'b0}}};
                        r_div_steps <= SW'(QW);
                        r_div_d     <= DVW'(dim_h);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_CI;
                    end
                end
                S_DIV_CI: begin
                    if (div_sts.done) begin
                        r_ci    <= $signed(ZW'(div_quot) - THREE_HALF_FX);
                        r_zr    <= '0;
                        r_zi    <= '0;
                        r_count <= '0;
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if (r_count >= r_limit) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_mul_a     <= MW'(r_zr);
                        r_mul_b     <= MW'(r_zr);
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_RR;
                    end
                end
                S_MUL_RR: begin
                    if (mul_sts.done) begin
                        r_rr        <= mul_prod;
                        r_mul_a     <= MW'(r_zi);
                        r_mul_b     <= MW'(r_zi);
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_II;
                    end
                end
                S_MUL_II: begin
                    if (mul_sts.done) begin
                        r_ii <= mul_prod;
                        // escaped: drop out with the current count
                        if (n_mag > $signed(FOUR_FX)) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_mul_a     <= $signed({r_zr, 1'b0});
                            r_mul_b     <= MW'(r_zi);
                            r_mul_start <= 1'b1;
                            r_state     <= S_MUL_RI;
                        end
                    end
                end
                S_MUL_RI: begin
                    if (mul_sts.done) begin
                        r_zr    <= ZW'(n_zr);
                        r_zi    <= ZW'(n_zi);
                        r_count <= r_count + 1'b1;
                        r_state <= S_LOOP;
                    end
                end
                S_SCALE: begin
                    if (r_limit == '0) begin
                        r_intensity <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        r_div_rem   <= DVW'(scaled[SCL_W-1:INT_W]);
                        r_div_low   <= {scaled[INT_W-1:0], {(QW - INT_W){1'b0}}};
                        r_div_steps <= SW'(INT_W);
                        r_div_d     <= DVW'(r_limit);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_N;
                    end
                end
                S_DIV_N: begin
                    if (div_sts.done) begin
                        r_intensity <= div_quot[INT_W-1:0];
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_count;
                        r_out_int   <= r_intensity;
                        r_out_oof   <= r_oof;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mbrot_mul #(
        .A_W   (MW),
        .FRAC  (FRAC_BITS),
        .RES_W (RW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    mbrot_div #(
        .Q_W (QW),
        .D_W (DVW),
        .S_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_rem   (r_div_rem),
        .i_low   (r_div_low),
        .i_steps (r_div_steps),
        .i_div   (r_div_d),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_intensity       = r_out_int;
    assign o_out_of_frame    = r_out_oof;
    assign o_cfg_ready       = 1'b1;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (r_count <= r_limit))
        else $error("iteration count beyond limit");

    a_oof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_frame) |-> (o_iteration_count == '0 && o_intensity == '0))
        else $error("out-of-frame beat carries nonzero result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

endmodule

### tb/sv/tb_mandelbrot_escape_time_pixel_unit.sv
// Self-checking testbench for the Mandelbrot escape-time pixel unit.
module tb_mandelbrot_escape_time_pixel_unit;
    import mbrot_pkg::*;

    localparam int FRAC        = 26;
    localparam int MAX_DIM     = 4096;
    localparam longint FOUR_Q  = longint'(4) << FRAC;
    localparam int RUN_LIMIT   = 8_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE      = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 2'd3;

    typedef struct packed {
        logic [LIMIT_W-1:0] count;
        logic [INT_W-1:0]   level;
        logic               oof;
    } t_escape;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
        logic                  known;
        t_escape               want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [COORD_W-1:0]    i_pixel_column;
    logic [COORD_W-1:0]    i_pixel_row;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [LIMIT_W-1:0]    o_iteration_count;
    logic [INT_W-1:0]      o_intensity;
    logic                  o_out_of_frame;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the frame registers
    logic [DIM_REG_W-1:0] frame_w    = RST_IMAGE_WIDTH;
    logic [DIM_REG_W-1:0] frame_h    = RST_IMAGE_HEIGHT;
    logic [LIMIT_W-1:0]   iter_limit = RST_ITERATION_LIMIT;

    t_escape   pending[$];
    t_plan_row plan[$];
    int        n_bad       = 0;
    int        cycle_count = 0;
    bit        no_idle     = 1'b0;
    bit        hold_out    = 1'b0;

    mandelbrot_escape_time_pixel_unit #(
        .FRAC_BITS     (FRAC),
        .MAX_DIMENSION (MAX_DIM)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pixel_column    (i_pixel_column),
        .i_pixel_row       (i_pixel_row),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_iteration_count (o_iteration_count),
        .o_intensity       (o_intensity),
        .o_out_of_frame    (o_out_of_frame),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Q38.26 product, floor of the exact product
    function automatic longint fxp_product(input longint a, input longint b);
        logic signed [127:0] wa, wb, p;
        wa = a;
        wb = b;
        p  = wa * wb;
        return p[FRAC+63:FRAC];
    endfunction

    function automatic t_escape escape_time(input logic [COORD_W-1:0] col,
                                            input logic [COORD_W-1:0] row);
        t_escape r;
        longint  w, h, cr, ci, zr, zi, rr, ii, nr;
        int      n;
        bit      escaped;
        w = (frame_w > MAX_DIM) ? MAX_DIM : longint'(frame_w);
        h = (frame_h > MAX_DIM) ? MAX_DIM : longint'(frame_h);
        r = '0;
        if (longint'(col) >= w || longint'(row) >= h) begin
            r.oof = 1'b1;
            return r;
        end
        cr = (longint'(col) << (FRAC + 2)) / w - (longint'(2) << FRAC);
        ci = ((longint'(row) * 3) << FRAC) / h - (longint'(3) << (FRAC - 1));
        zr = 0;
        zi = 0;
        n  = 0;
        escaped = 1'b0;
        while (n < int'(iter_limit) && !escaped) begin
            rr = fxp_product(zr, zr);
            ii = fxp_product(zi, zi);
            if (rr + ii > FOUR_Q) begin
                escaped = 1'b1;
            end else begin
                nr = rr - ii + cr;
                zi = fxp_product(zr * 2, zi) + ci;
                zr = nr;
                n++;
            end
        end
        r.count = n[LIMIT_W-1:0];
        r.level = (iter_limit == 0) ? '0 : INT_W'((n * 255) / int'(iter_limit));
        return r;
    endfunction

    task automatic plan_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        t_plan_row e;
        e = '0;
        e.col = col;
        e.row = row;
        plan.push_back(e);
    endtask

    task automatic plan_known(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic [LIMIT_W-1:0] count, input logic [INT_W-1:0] level,
                              input logic oof);
        t_plan_row e;
        e = '0;
        e.col        = col;
        e.row        = row;
        e.known      = 1'b1;
        e.want.count = count;
        e.want.level = level;
        e.want.oof   = oof;
        plan.push_back(e);
    endtask

    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        t_plan_row e;
        e = '0;
        e.is_write = 1'b1;
        e.idx      = idx;
        e.data     = data;
        plan.push_back(e);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:     frame_w = data[DIM_REG_W-1:0];
            CFG_IMAGE_HEIGHT:    frame_h = data[DIM_REG_W-1:0];
            CFG_ITERATION_LIMIT: iter_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid and wait until every pixel in flight has come out
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic known, input t_escape want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pixel_column <= col;
        i_pixel_row    <= row;
        do @(posedge i_clk); while (o_in_stall);
        pending.push_back(known ? want : escape_time(col, row));
        @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_dimension();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'd1;
            1: v = 16'(MAX_DIM);
            2: begin
                v = 16'h1FFF;
                v[15:13] = 3'($urandom_range(0, 7));
            end
            default: begin
                v = 16'($urandom_range(2, 700));
                v[15:13] = 3'($urandom_range(0, 7));
            end
        endcase
        return v;
    endfunction

    // stimulus: reset, directed table, then random phases
    initial begin : in_side
        logic [COORD_W-1:0]    col, row;
        logic [CFG_DATA_W-1:0] lim;
        int                    ew, eh;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_pixel_column = '0;
        i_pixel_row    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_IMAGE_WIDTH;
        i_cfg_data     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame 640 x 480, limit 256; the center maps to c = 0
        plan_known(12'd320, 12'd240, 16'd256, 8'd255, 1'b0);
        plan_pixel(12'd0, 12'd0);
        plan_pixel(12'd639, 12'd479);
        plan_pixel(12'd160, 12'd240);
        plan_known(12'd640, 12'd0, 16'd0, 8'd0, 1'b1);
        plan_known(12'd0, 12'd480, 16'd0, 8'd0, 1'b1);
        plan_known(12'd4095, 12'd4095, 16'd0, 8'd0, 1'b1);
        // zero limit: no iteration at all
        plan_write(CFG_ITERATION_LIMIT, 16'd0);
        plan_known(12'd320, 12'd240, 16'd0, 8'd0, 1'b0);
        plan_known(12'd4095, 12'd0, 16'd0, 8'd0, 1'b1);
        plan_write(CFG_ITERATION_LIMIT, 16'd1);
        plan_known(12'd320, 12'd240, 16'd1, 8'd255, 1'b0);
        plan_known(12'd0, 12'd0, 16'd1, 8'd255, 1'b0);
        // write to an index past the register list must not land anywhere
        plan_write(CFG_NO_SUCH_REG, 16'd0);
        plan_known(12'd320, 12'd240, 16'd1, 8'd255, 1'b0);
        // oversize dimensions clamp to the maximum
        plan_write(CFG_IMAGE_WIDTH, 16'hFFFF);
        plan_write(CFG_IMAGE_HEIGHT, 16'hFFFF);
        plan_known(12'd2048, 12'd2048, 16'd1, 8'd255, 1'b0);
        plan_pixel(12'd4095, 12'd4095);
        // zero width, then zero height
        plan_write(CFG_IMAGE_WIDTH, 16'd0);
        plan_known(12'd0, 12'd0, 16'd0, 8'd0, 1'b1);
        plan_write(CFG_IMAGE_WIDTH, 16'd1);
        plan_write(CFG_IMAGE_HEIGHT, 16'd0);
        plan_known(12'd0, 12'd0, 16'd0, 8'd0, 1'b1);
        plan_write(CFG_IMAGE_HEIGHT, 16'd1);
        plan_write(CFG_ITERATION_LIMIT, 16'd8);
        plan_pixel(12'd0, 12'd0);
        plan_known(12'd1, 12'd0, 16'd0, 8'd0, 1'b1);
        plan_known(12'd0, 12'd1, 16'd0, 8'd0, 1'b1);
        // full limit: the center never escapes
        plan_write(CFG_IMAGE_WIDTH, 16'd640);
        plan_write(CFG_IMAGE_HEIGHT, 16'd480);
        plan_write(CFG_ITERATION_LIMIT, 16'hFFFF);
        plan_known(12'd320, 12'd240, 16'hFFFF, 8'd255, 1'b0);
        plan_pixel(12'd0, 12'd0);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain_block();
                program_reg(plan[i].idx, plan[i].data);
            end else begin
                send_pixel(plan[i].col, plan[i].row, plan[i].known, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            if (p == 5)
                lim = 16'd255;
            else if (p == 9)
                lim = 16'd0;
            else
                lim = 16'($urandom_range(1, 48));
            program_reg(CFG_IMAGE_WIDTH, draw_dimension());
            program_reg(CFG_IMAGE_HEIGHT, draw_dimension());
            program_reg(CFG_ITERATION_LIMIT, lim);
            ew = (frame_w > MAX_DIM) ? MAX_DIM : int'(frame_w);
            eh = (frame_h > MAX_DIM) ? MAX_DIM : int'(frame_h);
            no_idle = (p % 4 == 3);
            if (p == 1)
                hold_out = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 6 && k == PHASE_ITEMS / 2)
                    drain_block();
                if (ew == 0 || eh == 0 || $urandom_range(0, 99) < 15) begin
                    col = COORD_W'($urandom);
                    row = COORD_W'($urandom);
                end else begin
                    col = COORD_W'($urandom_range(0, ew - 1));
                    row = COORD_W'($urandom_range(0, eh - 1));
                end
                send_pixel(col, row, 1'b0, '0);
            end
        end

        drain_block();
        repeat (SETTLE) @(negedge i_clk);
        if (n_bad == 0)
            $display("tb_mandelbrot_escape_time_pixel_unit: PASS");
        else
            $display("tb_mandelbrot_escape_time_pixel_unit: FAIL");
        $finish;
    end

    // result side back-pressure
    initial begin : out_side
        int n;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_out) begin
                // hold long enough for the unit to fill and stall its input
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 16);
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_escape want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                if (n_bad < 10)
                    $display("unexpected beat: count %0d level %0d oof %0b",
                             o_iteration_count, o_intensity, o_out_of_frame);
                n_bad++;
            end else begin
                want = pending.pop_front();
                if (o_iteration_count !== want.count || o_intensity !== want.level ||
                    o_out_of_frame !== want.oof) begin
                    if (n_bad < 10)
                        $display("mismatch: count %0d/%0d level %0d/%0d oof %0b/%0b (exp/got)",
                                 want.count, o_iteration_count, want.level, o_intensity,
                                 want.oof, o_out_of_frame);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_mandelbrot_escape_time_pixel_unit: FAIL");
            $finish;
        end
    end

endmodule
